// ===== src/drop_driven_bitrate_controller_unit_defines.svh =====
// Assertion macros for the drop driven bitrate controller.
// Both expect clk and arst_n in scope at the point of use.
`ifndef DROP_DRIVEN_BITRATE_CONTROLLER_UNIT_DEFINES_SVH
`define DROP_DRIVEN_BITRATE_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DDBC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ddbc: same-cycle check failed");
`define DDBC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddbc: next-cycle check failed");
`else
`define DDBC_ASSERT_IMP(lbl, ante, cons)
`define DDBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/ddbc_pkg.sv =====
package ddbc_pkg;

	localparam int RATE_W  = 20;
	localparam int GOP_W   = 6;
	localparam int TIME_W  = 48;
	localparam int DROP_W  = 16;
	localparam int MS_W    = 16;
	localparam int US_W    = 26;
	localparam int MUL_W   = 34;
	localparam int DELTA_W = 22;
	localparam int RAW_W   = 23;
	localparam int PROD_W  = RATE_W + MUL_W;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [GOP_W-1:0] GOP_NORMAL = 6'd30;
	localparam logic [GOP_W-1:0] GOP_LONG   = 6'd45;

	localparam int unsigned US_PER_MS = 1000;
	// floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT for every x below 2**30
	localparam longint unsigned PCT_RECIP = 64'd42949673;
	localparam int PCT_SHIFT = 32;

	localparam logic REQ_DROP = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET   = 3'd0,
		REG_MIN      = 3'd1,
		REG_MAX      = 3'd2,
		REG_WINDOW   = 3'd3,
		REG_THRESH   = 3'd4,
		REG_DOWN_PCT = 3'd5,
		REG_UP_PCT   = 3'd6,
		REG_COOLDOWN = 3'd7
	} reg_idx_t;

	localparam logic [7:0]        RST_TARGET   = 8'd0;
	localparam logic [RATE_W-1:0] RST_MIN      = 20'd500;
	localparam logic [RATE_W-1:0] RST_MAX      = 20'd8000;
	localparam logic [MS_W-1:0]   RST_WINDOW   = 16'd1000;
	localparam logic [DROP_W-1:0] RST_THRESH   = 16'd1;
	localparam logic [6:0]        RST_DOWN_PCT = 7'd20;
	localparam logic [7:0]        RST_UP_PCT   = 8'd5;
	localparam logic [MS_W-1:0]   RST_COOLDOWN = 16'd5000;

	localparam int DEF_INIT_BITRATE = 2000;

	// Working view of the registers: times in microseconds, percentages as
	// scaled reciprocals ready for a single multiply.
	typedef struct packed {
		logic [7:0]        target_stream;
		logic [RATE_W-1:0] min_bitrate;
		logic [RATE_W-1:0] max_bitrate;
		logic [US_W-1:0]   window_us;
		logic [DROP_W-1:0] drop_threshold;
		logic [MUL_W-1:0]  down_mul;
		logic [MUL_W-1:0]  up_mul;
		logic [US_W-1:0]   cooldown_us;
	} cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] bitrate;
		logic [GOP_W-1:0]  gop;
		logic [TIME_W-1:0] window_start;
		logic [TIME_W-1:0] last_adjust;
		logic [DROP_W-1:0] drop_events;
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [7:0]        src_stream;
		logic [TIME_W-1:0] now_us;
	} item_t;

	typedef struct packed {
		state_t st_next;
		logic   adjusted;
		logic   cfg_err;
	} step_res_t;

endpackage

// ===== src/drop_driven_bitrate_controller_unit.sv =====
// Drop driven bitrate controller.
// Input channel (in_valid/in_stall): one word is a drop report (req_type 0,
// src_stream) or a time tick (req_type 1, now_us in microseconds). Every word
// gives exactly one result word on the output channel (out_valid/out_stall):
// the bitrate and GOP in effect afterwards, an adjusted flag and config_error.
// Path: a word taken in goes to the input register, then to the result register,
// where out_valid shows it until the receiver takes it.
// Throughput: one word per cycle while the receiver does not stall. The update
// of bitrate, GOP, window and drop count is combinational and closes through
// the state registers: a 20 x 34 bit multiply by a scaled percent reciprocal,
// then subtract or add and clamp.
// While the receiver stalls, the result is held and one more word is still
// taken into the input register; in_stall rises only when both are full.
// Reset clears the registers to their documented values, the bitrate to
// INIT_BITRATE clamped to the reset bounds, GOP 30, counters and times 0.
// Registers are written over the APB port; pready is always high.
`include "drop_driven_bitrate_controller_unit_defines.svh"
module drop_driven_bitrate_controller_unit #(
	parameter int INIT_BITRATE = ddbc_pkg::DEF_INIT_BITRATE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ddbc_pkg::ADDR_W-1:0]          paddr,
	input  logic [ddbc_pkg::DATA_W-1:0]          pwdata,
	output logic [ddbc_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [7:0]                           src_stream,
	input  logic [ddbc_pkg::TIME_W-1:0]          now_us,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ddbc_pkg::RATE_W-1:0]          rate_kbps,
	output logic [ddbc_pkg::GOP_W-1:0]           gop_len,
	output logic                                 adjusted,
	output logic                                 config_error
);

	localparam logic [ddbc_pkg::RATE_W-1:0] INIT_RATE =
		(INIT_BITRATE < int'(ddbc_pkg::RST_MIN)) ? ddbc_pkg::RST_MIN :
		(INIT_BITRATE > int'(ddbc_pkg::RST_MAX)) ? ddbc_pkg::RST_MAX :
		ddbc_pkg::RATE_W'(INIT_BITRATE);

	ddbc_pkg::cfg_t        cfg;
	ddbc_pkg::state_t      st_q;
	ddbc_pkg::item_t       item_s1;
	ddbc_pkg::step_res_t   res;
	logic                  valid_s1;
	logic                  out_valid_q;
	logic [ddbc_pkg::RATE_W-1:0] bitrate_q;
	logic [ddbc_pkg::GOP_W-1:0]  gop_q;
	logic                  adjusted_q;
	logic                  cfg_err_q;
	logic                  out_blocked;
	logic                  load_s1;
	logic                  fire_s1;

	assign pready = 1'b1;

	ddbc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ddbc_step u_step (
		.cfg  (cfg),
		.st   (st_q),
		.item (item_s1),
		.res  (res)
	);

	assign out_blocked = out_valid_q && out_stall;
	assign in_stall    = valid_s1 && out_blocked;
	assign load_s1     = in_valid && !in_stall;
	assign fire_s1     = valid_s1 && !out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.req_type   <= req_type;
			item_s1.src_stream <= src_stream;
			item_s1.now_us     <= now_us;
		end
	end

	// Advance the controller state only as the word moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.bitrate      <= INIT_RATE;
			st_q.gop          <= ddbc_pkg::GOP_NORMAL;
			st_q.window_start <= '0;
			st_q.last_adjust  <= '0;
			st_q.drop_events  <= '0;
		end else if (fire_s1) begin
			st_q <= res.st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			bitrate_q  <= res.st_next.bitrate;
			gop_q      <= res.st_next.gop;
			adjusted_q <= res.adjusted;
			cfg_err_q  <= res.cfg_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign rate_kbps    = bitrate_q;
	assign gop_len      = gop_q;
	assign adjusted     = adjusted_q;
	assign config_error = cfg_err_q;

	`DDBC_ASSERT_IMP(a_adjust_not_frozen, out_valid_q && adjusted_q, !cfg_err_q)
	`DDBC_ASSERT_IMP(a_gop_legal, out_valid_q, (gop_q == ddbc_pkg::GOP_NORMAL) || (gop_q == ddbc_pkg::GOP_LONG))
	`DDBC_ASSERT_NXT(a_frozen_state, fire_s1 && res.cfg_err, $stable(st_q))
	`DDBC_ASSERT_NXT(a_adjust_time, fire_s1 && res.adjusted, st_q.last_adjust == $past(item_s1.now_us))

endmodule

// ===== src/ddbc_cfg.sv =====
module ddbc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ddbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ddbc_pkg::DATA_W-1:0]   pwdata,
	output logic [ddbc_pkg::DATA_W-1:0]   prdata,
	output ddbc_pkg::cfg_t                cfg
);

	function automatic logic [ddbc_pkg::US_W-1:0] ms_to_us(input logic [ddbc_pkg::MS_W-1:0] ms);
		ms_to_us = ddbc_pkg::US_W'(ms) * ddbc_pkg::US_W'(ddbc_pkg::US_PER_MS);
	endfunction

	function automatic logic [ddbc_pkg::MUL_W-1:0] pct_mul(input logic [7:0] pct);
		pct_mul = ddbc_pkg::MUL_W'(pct) * ddbc_pkg::MUL_W'(ddbc_pkg::PCT_RECIP);
	endfunction

	logic [7:0]                    target_q;
	logic [ddbc_pkg::RATE_W-1:0]   min_q;
	logic [ddbc_pkg::RATE_W-1:0]   max_q;
	logic [ddbc_pkg::MS_W-1:0]     window_ms_q;
	logic [ddbc_pkg::US_W-1:0]     window_us_q;
	logic [ddbc_pkg::DROP_W-1:0]   thresh_q;
	logic [6:0]                    down_pct_q;
	logic [ddbc_pkg::MUL_W-1:0]    down_mul_q;
	logic [7:0]                    up_pct_q;
	logic [ddbc_pkg::MUL_W-1:0]    up_mul_q;
	logic [ddbc_pkg::MS_W-1:0]     cooldown_ms_q;
	logic [ddbc_pkg::US_W-1:0]     cooldown_us_q;

	logic                          wr_en;
	ddbc_pkg::reg_idx_t            idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = ddbc_pkg::reg_idx_t'(paddr[ddbc_pkg::ADDR_W-1:2]);

	// Derived values are formed at write time so the update path sees them ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= ddbc_pkg::RST_TARGET;
			min_q         <= ddbc_pkg::RST_MIN;
			max_q         <= ddbc_pkg::RST_MAX;
			window_ms_q   <= ddbc_pkg::RST_WINDOW;
			window_us_q   <= ms_to_us(ddbc_pkg::RST_WINDOW);
			thresh_q      <= ddbc_pkg::RST_THRESH;
			down_pct_q    <= ddbc_pkg::RST_DOWN_PCT;
			down_mul_q    <= pct_mul({1'b0, ddbc_pkg::RST_DOWN_PCT});
			up_pct_q      <= ddbc_pkg::RST_UP_PCT;
			up_mul_q      <= pct_mul(ddbc_pkg::RST_UP_PCT);
			cooldown_ms_q <= ddbc_pkg::RST_COOLDOWN;
			cooldown_us_q <= ms_to_us(ddbc_pkg::RST_COOLDOWN);
		end else if (wr_en) begin
			case (idx)
				ddbc_pkg::REG_TARGET: begin
					target_q <= pwdata[7:0];
				end
				ddbc_pkg::REG_MIN: begin
					min_q <= pwdata[ddbc_pkg::RATE_W-1:0];
				end
				ddbc_pkg::REG_MAX: begin
					max_q <= pwdata[ddbc_pkg::RATE_W-1:0];
				end
				ddbc_pkg::REG_WINDOW: begin
					window_ms_q <= pwdata[ddbc_pkg::MS_W-1:0];
					window_us_q <= ms_to_us(pwdata[ddbc_pkg::MS_W-1:0]);
				end
				ddbc_pkg::REG_THRESH: begin
					thresh_q <= pwdata[ddbc_pkg::DROP_W-1:0];
				end
				ddbc_pkg::REG_DOWN_PCT: begin
					down_pct_q <= pwdata[6:0];
					down_mul_q <= pct_mul({1'b0, pwdata[6:0]});
				end
				ddbc_pkg::REG_UP_PCT: begin
					up_pct_q <= pwdata[7:0];
					up_mul_q <= pct_mul(pwdata[7:0]);
				end
				ddbc_pkg::REG_COOLDOWN: begin
					cooldown_ms_q <= pwdata[ddbc_pkg::MS_W-1:0];
					cooldown_us_q <= ms_to_us(pwdata[ddbc_pkg::MS_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			ddbc_pkg::REG_TARGET:   prdata = ddbc_pkg::DATA_W'(target_q);
			ddbc_pkg::REG_MIN:      prdata = ddbc_pkg::DATA_W'(min_q);
			ddbc_pkg::REG_MAX:      prdata = ddbc_pkg::DATA_W'(max_q);
			ddbc_pkg::REG_WINDOW:   prdata = ddbc_pkg::DATA_W'(window_ms_q);
			ddbc_pkg::REG_THRESH:   prdata = ddbc_pkg::DATA_W'(thresh_q);
			ddbc_pkg::REG_DOWN_PCT: prdata = ddbc_pkg::DATA_W'(down_pct_q);
			ddbc_pkg::REG_UP_PCT:   prdata = ddbc_pkg::DATA_W'(up_pct_q);
			ddbc_pkg::REG_COOLDOWN: prdata = ddbc_pkg::DATA_W'(cooldown_ms_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.target_stream  = target_q;
	assign cfg.min_bitrate    = min_q;
	assign cfg.max_bitrate    = max_q;
	assign cfg.window_us      = window_us_q;
	assign cfg.drop_threshold = thresh_q;
	assign cfg.down_mul       = down_mul_q;
	assign cfg.up_mul         = up_mul_q;
	assign cfg.cooldown_us    = cooldown_us_q;

endmodule

// ===== src/ddbc_step.sv =====
module ddbc_step (
	input  ddbc_pkg::cfg_t      cfg,
	input  ddbc_pkg::state_t    st,
	input  ddbc_pkg::item_t     item,
	output ddbc_pkg::step_res_t res
);

	logic                           cfg_err;
	logic [ddbc_pkg::TIME_W-1:0]    since_window;
	logic [ddbc_pkg::TIME_W-1:0]    since_adjust;
	logic                           boundary;
	logic                           go_down;
	logic                           go_up;
	logic [ddbc_pkg::MUL_W-1:0]     mul_sel;
	logic [ddbc_pkg::PROD_W-1:0]    prod;
	logic [ddbc_pkg::DELTA_W-1:0]   delta;
	logic [ddbc_pkg::DELTA_W-1:0]   delta_nz;
	logic [ddbc_pkg::RAW_W-1:0]     raw;
	logic [ddbc_pkg::RATE_W-1:0]    clamped;

	assign cfg_err = cfg.min_bitrate > cfg.max_bitrate;

	// Comparing microseconds against ms*1000 matches the truncated ms compare.
	assign since_window = item.now_us - st.window_start;
	assign since_adjust = item.now_us - st.last_adjust;
	assign boundary = (item.req_type == ddbc_pkg::REQ_TICK) && (item.now_us != '0)
		&& (since_window >= ddbc_pkg::TIME_W'(cfg.window_us));

	assign go_down = st.drop_events >= cfg.drop_threshold;
	assign go_up   = (st.drop_events == '0)
		&& (since_adjust >= ddbc_pkg::TIME_W'(cfg.cooldown_us));

	// One shared multiply: current rate times the chosen percent reciprocal.
	assign mul_sel  = go_down ? cfg.down_mul : cfg.up_mul;
	assign prod     = ddbc_pkg::PROD_W'(st.bitrate) * ddbc_pkg::PROD_W'(mul_sel);
	assign delta    = prod[ddbc_pkg::PCT_SHIFT +: ddbc_pkg::DELTA_W];
	assign delta_nz = (delta == '0) ? ddbc_pkg::DELTA_W'(1) : delta;

	always_comb begin
		if (go_down) begin
			if (delta_nz > ddbc_pkg::DELTA_W'(st.bitrate)) begin
				raw = '0;
			end else begin
				raw = ddbc_pkg::RAW_W'(st.bitrate) - ddbc_pkg::RAW_W'(delta_nz);
			end
		end else begin
			raw = ddbc_pkg::RAW_W'(st.bitrate) + ddbc_pkg::RAW_W'(delta_nz);
		end
		if (raw < ddbc_pkg::RAW_W'(cfg.min_bitrate)) begin
			clamped = cfg.min_bitrate;
		end else if (raw > ddbc_pkg::RAW_W'(cfg.max_bitrate)) begin
			clamped = cfg.max_bitrate;
		end else begin
			clamped = raw[ddbc_pkg::RATE_W-1:0];
		end
	end

	always_comb begin
		res.st_next  = st;
		res.adjusted = 1'b0;
		res.cfg_err  = cfg_err;
		if (!cfg_err) begin
			if (item.req_type == ddbc_pkg::REQ_DROP) begin
				if (item.src_stream == cfg.target_stream
					&& st.drop_events != ddbc_pkg::DROP_MAX) begin
					res.st_next.drop_events = st.drop_events + ddbc_pkg::DROP_W'(1);
				end
			end else if (boundary) begin
				if (go_down || go_up) begin
					res.st_next.bitrate     = clamped;
					res.st_next.gop         = go_down ? ddbc_pkg::GOP_LONG : ddbc_pkg::GOP_NORMAL;
					res.st_next.last_adjust = item.now_us;
					res.adjusted            = 1'b1;
				end
				res.st_next.drop_events  = '0;
				res.st_next.window_start = item.now_us;
			end
		end
	end

endmodule

// ===== verif/tb_drop_driven_bitrate_controller_unit.sv =====
module tb_drop_driven_bitrate_controller_unit;
	import ddbc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PCT_SCALE   = 100;
	localparam int PHASES      = 9;
	localparam int PHASE_WORDS = 47;
	localparam int MAX_RATE    = 1000000;

	typedef struct packed {
		logic [RATE_W-1:0] bitrate;
		logic [GOP_W-1:0]  gop;
		logic              adjusted;
		logic              cfg_err;
	} rate_result_t;

	typedef struct {
		bit           is_cfg;
		reg_idx_t     idx;
		logic [31:0]  value;
		item_t        word;
		bit           typed;
		rate_result_t want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [7:0]          src_stream;
	logic [TIME_W-1:0]   now_us;
	logic                out_valid;
	logic                out_stall;
	logic [RATE_W-1:0]   rate_kbps;
	logic [GOP_W-1:0]    gop_len;
	logic                adjusted;
	logic                config_error;

	drop_driven_bitrate_controller_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.src_stream   (src_stream),
		.now_us       (now_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rate_kbps    (rate_kbps),
		.gop_len      (gop_len),
		.adjusted     (adjusted),
		.config_error (config_error)
	);

	// controller registers as last written
	logic [7:0]        cfg_target;
	logic [RATE_W-1:0] cfg_min;
	logic [RATE_W-1:0] cfg_max;
	logic [MS_W-1:0]   cfg_window;
	logic [DROP_W-1:0] cfg_thresh;
	logic [6:0]        cfg_down;
	logic [7:0]        cfg_up;
	logic [MS_W-1:0]   cfg_cooldown;

	// controller state
	logic [RATE_W-1:0] rate_now;
	logic [GOP_W-1:0]  gop_now;
	logic [TIME_W-1:0] window_open;
	logic [TIME_W-1:0] last_change;
	logic [DROP_W-1:0] drop_tally;

	rate_result_t      owed_results[$];
	plan_row_t         plan[$];
	int                mismatches;
	int                n_words;
	int                n_checked;
	int                n_writes;
	int                n_down;
	int                n_up;
	int                n_frozen;
	int                cycle_count;
	int                hold_cycles;
	bit                lazy_sender;
	bit                lazy_receiver;
	logic [TIME_W-1:0] clock_cursor;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[TIME_W-1:0];
	endfunction

	function automatic logic [RATE_W-1:0] clamp_rate(input longint unsigned v);
		if (v < cfg_min)
			return cfg_min;
		if (v > cfg_max)
			return cfg_max;
		return v[RATE_W-1:0];
	endfunction

	function automatic rate_result_t advance_controller(input item_t w);
		rate_result_t      r;
		logic [TIME_W-1:0] since_open;
		logic [TIME_W-1:0] since_change;
		longint unsigned   cur;
		longint unsigned   delta;
		r.adjusted = 1'b0;
		r.cfg_err  = cfg_min > cfg_max;
		if (r.cfg_err) begin
			n_frozen++;
		end else if (w.req_type == REQ_DROP) begin
			if (w.src_stream == cfg_target && drop_tally != DROP_MAX)
				drop_tally = drop_tally + 1'b1;
		end else if (w.now_us != '0) begin
			// elapsed times wrap at 48 bits, then truncate to ms
			since_open   = w.now_us - window_open;
			since_change = w.now_us - last_change;
			if (since_open / US_PER_MS >= cfg_window) begin
				cur = rate_now;
				if (drop_tally >= cfg_thresh) begin
					delta = cur * cfg_down / PCT_SCALE;
					if (delta == 0)
						delta = 1;
					rate_now    = clamp_rate((delta > cur) ? 0 : cur - delta);
					gop_now     = GOP_LONG;
					last_change = w.now_us;
					r.adjusted  = 1'b1;
					n_down++;
				end else if (drop_tally == 0 && since_change / US_PER_MS >= cfg_cooldown) begin
					delta = cur * cfg_up / PCT_SCALE;
					if (delta == 0)
						delta = 1;
					rate_now    = clamp_rate(cur + delta);
					gop_now     = GOP_NORMAL;
					last_change = w.now_us;
					r.adjusted  = 1'b1;
					n_up++;
				end
				drop_tally  = '0;
				window_open = w.now_us;
			end
		end
		r.bitrate = rate_now;
		r.gop     = gop_now;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch after %0d results: %s", n_checked, what);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TARGET:   cfg_target   = value[7:0];
			REG_MIN:      cfg_min      = value[RATE_W-1:0];
			REG_MAX:      cfg_max      = value[RATE_W-1:0];
			REG_WINDOW:   cfg_window   = value[MS_W-1:0];
			REG_THRESH:   cfg_thresh   = value[DROP_W-1:0];
			REG_DOWN_PCT: cfg_down     = value[6:0];
			REG_UP_PCT:   cfg_up       = value[7:0];
			REG_COOLDOWN: cfg_cooldown = value[MS_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic send_word(input item_t w, input bit typed, input rate_result_t want);
		int           gap;
		rate_result_t predicted;
		gap = lazy_sender ? $urandom_range(0, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= w.req_type;
		src_stream <= w.src_stream;
		now_us     <= w.now_us;
		do @(posedge clk); while (in_stall);
		predicted = advance_controller(w);
		owed_results.push_back(typed ? want : predicted);
		n_words++;
	endtask

	// drop valid and let the pipeline empty before touching registers
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void plan_cfg(input reg_idx_t idx, input logic [31:0] value);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.value  = value;
		row.word   = '0;
		row.typed  = 1'b0;
		row.want   = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_word(input logic rt, input logic [7:0] sid,
			input logic [TIME_W-1:0] t, input bit typed, input rate_result_t want);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx    = REG_TARGET;
		row.value  = '0;
		row.word   = {rt, sid, t};
		row.typed  = typed;
		row.want   = want;
		plan.push_back(row);
	endfunction

	// receiver: check each accepted result word, then draw the next stall
	initial begin
		rate_result_t want;
		int           stall_left;
		out_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result word with nothing owed");
				end else begin
					want = owed_results.pop_front();
					if (rate_kbps !== want.bitrate)
						report_mismatch($sformatf("rate_kbps %0d, want %0d",
							rate_kbps, want.bitrate));
					if (gop_len !== want.gop)
						report_mismatch($sformatf("gop_len %0d, want %0d", gop_len, want.gop));
					if (adjusted !== want.adjusted)
						report_mismatch($sformatf("adjusted %b, want %b",
							adjusted, want.adjusted));
					if (config_error !== want.cfg_err)
						report_mismatch($sformatf("config_error %b, want %b",
							config_error, want.cfg_err));
				end
				n_checked++;
				stall_left = lazy_receiver ? $urandom_range(0, 11) : 0;
			end
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int          p;
		int          k;
		int          roll;
		int          drop_pct;
		int unsigned lo;
		int unsigned hi;
		item_t       w;

		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		req_type   = REQ_DROP;
		src_stream = '0;
		now_us     = '0;

		mismatches    = 0;
		n_words       = 0;
		n_checked     = 0;
		n_writes      = 0;
		n_down        = 0;
		n_up          = 0;
		n_frozen      = 0;
		hold_cycles   = 0;
		lazy_sender   = 1'b1;
		lazy_receiver = 1'b1;

		cfg_target   = RST_TARGET;
		cfg_min      = RST_MIN;
		cfg_max      = RST_MAX;
		cfg_window   = RST_WINDOW;
		cfg_thresh   = RST_THRESH;
		cfg_down     = RST_DOWN_PCT;
		cfg_up       = RST_UP_PCT;
		cfg_cooldown = RST_COOLDOWN;
		rate_now     = clamp_rate(DEF_INIT_BITRATE);
		gop_now      = GOP_NORMAL;
		window_open  = '0;
		last_change  = '0;
		drop_tally   = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: first drop counts, zero tick ignored, then a step down and two steps up
		plan_word(REQ_DROP, 8'd0, 48'd0, 1'b1, {20'd2000, GOP_NORMAL, 1'b0, 1'b0});
		plan_word(REQ_TICK, 8'd0, 48'd0, 1'b1, {20'd2000, GOP_NORMAL, 1'b0, 1'b0});
		plan_word(REQ_TICK, 8'd0, 48'd500000, 1'b1, {20'd2000, GOP_NORMAL, 1'b0, 1'b0});
		plan_word(REQ_TICK, 8'd0, 48'd1000000, 1'b1, {20'd1600, GOP_LONG, 1'b1, 1'b0});
		plan_word(REQ_DROP, 8'd255, 48'd0, 1'b1, {20'd1600, GOP_LONG, 1'b0, 1'b0});
		plan_word(REQ_TICK, 8'd0, 48'd2000000, 1'b1, {20'd1600, GOP_LONG, 1'b0, 1'b0});
		plan_word(REQ_TICK, 8'd0, 48'd6000000, 1'b1, {20'd1680, GOP_NORMAL, 1'b1, 1'b0});
		plan_word(REQ_TICK, 8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1,
			{20'd1764, GOP_NORMAL, 1'b1, 1'b0});
		// wraps to only 1000 us after the previous tick
		plan_word(REQ_TICK, 8'd0, 48'd999, 1'b1, {20'd1764, GOP_NORMAL, 1'b0, 1'b0});
		// min above max: frozen
		plan_cfg(REG_MIN, 32'd9000);
		plan_word(REQ_DROP, 8'd0, 48'd0, 1'b1, {20'd1764, GOP_NORMAL, 1'b0, 1'b1});
		plan_word(REQ_TICK, 8'd0, 48'h8000_0000_0000, 1'b1,
			{20'd1764, GOP_NORMAL, 1'b0, 1'b1});
		// zero window and zero threshold: every tick steps down, full percentage
		plan_cfg(REG_MIN, 32'd1);
		plan_cfg(REG_MAX, MAX_RATE);
		plan_cfg(REG_WINDOW, 32'd0);
		plan_cfg(REG_THRESH, 32'd0);
		plan_cfg(REG_DOWN_PCT, 32'd100);
		plan_word(REQ_TICK, 8'd0, 48'd1, 1'b0, '0);
		plan_word(REQ_TICK, 8'd0, 48'd2, 1'b0, '0);
		// step up with zero percent, then the widest one, up into the bounds
		plan_cfg(REG_THRESH, 32'hFFFF);
		plan_cfg(REG_COOLDOWN, 32'd0);
		plan_cfg(REG_UP_PCT, 32'd0);
		plan_word(REQ_TICK, 8'd0, 48'd3, 1'b0, '0);
		plan_cfg(REG_UP_PCT, 32'd255);
		plan_word(REQ_TICK, 8'd0, 48'd4, 1'b0, '0);
		plan_cfg(REG_MIN, MAX_RATE);
		plan_word(REQ_TICK, 8'd0, 48'd5, 1'b0, '0);
		plan_cfg(REG_MIN, 32'd1);
		plan_word(REQ_TICK, 8'd0, 48'd6, 1'b0, '0);
		// decrease larger than the bitrate
		plan_cfg(REG_DOWN_PCT, 32'd127);
		plan_cfg(REG_THRESH, 32'd0);
		plan_word(REQ_TICK, 8'd0, 48'd7, 1'b0, '0);
		// widest window and cooldown; a window with drops under threshold
		plan_cfg(REG_TARGET, 32'd255);
		plan_cfg(REG_THRESH, 32'd3);
		plan_cfg(REG_WINDOW, 32'hFFFF);
		plan_cfg(REG_COOLDOWN, 32'hFFFF);
		plan_cfg(REG_DOWN_PCT, 32'd0);
		plan_word(REQ_DROP, 8'd255, 48'h5555_5555_5555, 1'b0, '0);
		plan_word(REQ_DROP, 8'd0, 48'hAAAA_AAAA_AAAA, 1'b0, '0);
		plan_word(REQ_TICK, 8'd0, 48'd65535007, 1'b0, '0);
		plan_word(REQ_TICK, 8'd0, 48'd131070007, 1'b0, '0);
		plan_cfg(REG_THRESH, 32'd1);
		plan_word(REQ_DROP, 8'd255, 48'd0, 1'b0, '0);
		plan_word(REQ_TICK, 8'd0, 48'd196605007, 1'b0, '0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				send_word(plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		clock_cursor = 48'd300000000;
		for (p = 0; p < PHASES; p++) begin
			drain_results();
			roll = (p == 4) ? 0 : $urandom_range(1, 9);
			if (roll == 0) begin
				lo = $urandom_range(2, MAX_RATE);
				hi = $urandom_range(1, lo - 1);
			end else if (roll == 1) begin
				lo = $urandom_range(1, MAX_RATE);
				hi = lo;
			end else begin
				lo = $urandom_range(1, 3000);
				hi = (roll == 2) ? MAX_RATE : $urandom_range(lo, 200000);
			end
			write_reg(REG_MIN, lo);
			write_reg(REG_MAX, hi);
			write_reg(REG_TARGET, $urandom_range(0, 255));
			write_reg(REG_WINDOW, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 8));
			write_reg(REG_THRESH, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 4));
			write_reg(REG_DOWN_PCT, ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 100));
			write_reg(REG_UP_PCT, $urandom_range(0, 255));
			write_reg(REG_COOLDOWN, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 20));

			lazy_sender   = (p % 3 != 2) && (p != 1);
			lazy_receiver = (p % 3 != 2);
			drop_pct      = $urandom_range(10, 70);
			for (k = 0; k < PHASE_WORDS; k++) begin
				// hold the output long enough for the block to back up
				if (p == 1 && k == 10)
					hold_cycles = 40;
				if (p == 3 && k == 25)
					drain_results();
				w.src_stream = 8'($urandom_range(0, 255));
				w.now_us     = rand48();
				if ($urandom_range(0, 99) < drop_pct) begin
					w.req_type = REQ_DROP;
					if ($urandom_range(0, 4) != 0)
						w.src_stream = cfg_target;
				end else begin
					w.req_type = REQ_TICK;
					roll = $urandom_range(0, 19);
					if (roll == 0) begin
						w.now_us = '0;
					end else if (roll == 1) begin
						clock_cursor = w.now_us;
					end else begin
						clock_cursor = clock_cursor +
							$urandom_range(0, (cfg_window + 1) * 2000);
						w.now_us = clock_cursor;
					end
				end
				send_word(w, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch("results still owed at the end");
		$display("run: %0d words checked, %0d register writes", n_checked, n_writes);
		$display("run: %0d step downs, %0d step ups, %0d words frozen by bad bounds",
			n_down, n_up, n_frozen);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
